### hw/rtl/amfm_pkg.sv
// ----------------------------------------------------------------------------
// amfm_pkg
// Shared types, widths and codes of the angular momentum fusion block.
// ----------------------------------------------------------------------------
package amfm_pkg;

   localparam int SPIN_W      = 5;
   localparam int MULT_IN_W   = 16;
   localparam int MAX_IN_SPIN = 31;
   localparam int MULT_BITS   = 16;
   localparam int PROD_W      = 2 * MULT_BITS;
   localparam int BIN_W       = 6;
   localparam int NBINS       = 2 * MAX_IN_SPIN + 2;
   localparam int SUM_W       = 40;
   localparam int MAX_OUT     = 63;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ONLY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SPIN = 2'd1;

   typedef struct packed {
      logic [SPIN_W-1:0]    spin;
      logic [MULT_BITS-1:0] mult;
   } entry_type;

   typedef struct packed {
      logic [BIN_W-1:0] rd_bin;
      logic             wr_en;
      logic [BIN_W-1:0] wr_bin;
      logic             clear;
   } hist_ctl_type;

   function automatic logic [BIN_W-1:0] degeneracy(input logic [BIN_W-1:0] spin);
      logic [BIN_W:0] d;
      d = {1'b0, spin} + (BIN_W + 1)'(1);
      if (d > (BIN_W + 1)'(MAX_OUT)) begin
         return BIN_W'(MAX_OUT);
      end
      return d[BIN_W-1:0];
   endfunction

endpackage

### hw/rtl/amfm_hist.sv
// ----------------------------------------------------------------------------
// amfm_hist
// Spin histogram: bin memory with touched bits and a saturating accumulator.
// ----------------------------------------------------------------------------
module amfm_hist (
   input  logic                           clock,
   input  logic                           reset,
   input  amfm_pkg::hist_ctl_type         ctl,
   input  logic [amfm_pkg::PROD_W-1:0]    addend,
   output logic                           rd_seen,
   output logic [amfm_pkg::SUM_W-1:0]     rd_sum,
   output logic                           rd_sat
);
   import amfm_pkg::*;

   logic [SUM_W:0]     mem [NBINS];
   logic [SUM_W:0]     q_ff;
   logic               seen_q_ff;
   logic [NBINS-1:0]   seen_ff;
   logic [NBINS-1:0]   seen_in;
   logic [SUM_W:0]     acc;
   logic [SUM_W:0]     wdata;

   assign rd_seen = seen_q_ff;
   assign rd_sum  = seen_q_ff ? q_ff[SUM_W-1:0] : '0;
   assign rd_sat  = seen_q_ff & q_ff[SUM_W];

   always_comb begin
      acc = {1'b0, rd_sum} + (SUM_W + 1)'(addend);
      if (acc[SUM_W]) begin
         wdata = {1'b1, {SUM_W{1'b1}}};
      end else begin
         wdata = {rd_sat, acc[SUM_W-1:0]};
      end
   end

   always_comb begin
      if (ctl.clear) begin
         seen_in = '0;
      end else if (ctl.wr_en) begin
         seen_in = seen_ff | (NBINS'(1) << ctl.wr_bin);
      end else begin
         seen_in = seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= mem[ctl.rd_bin];
      if (ctl.wr_en) begin
         mem[ctl.wr_bin] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         seen_q_ff <= 1'b0;
      end else begin
         seen_ff   <= seen_in;
         seen_q_ff <= seen_ff[ctl.rd_bin];
      end
   end

endmodule

### hw/rtl/angular_momentum_fusion_multiplicity.sv
// ----------------------------------------------------------------------------
// angular_momentum_fusion_multiplicity
// Clebsch-Gordan series multiplicity counter for fusing two SU(2) bonds.
// ----------------------------------------------------------------------------
// A transaction is taken on a clock edge with start high and busy low.
// func 0 loads a first-bond entry into the store if it is not full; busy stays low.
// func 1 fuses a second-bond entry: for each stored entry the store is read,
// one multiply forms the product, then one histogram bin is updated per cycle
// through the shared read-add-write path. With final_entry set the block then
// emits: full mode scans all 64 bins one per cycle, target mode reads one bin;
// the last result sits on the ports in the same cycle as busy drops.
// Results leave on rsp_valid, one cycle each, ascending spin, run_end on the
// last; the receiver cannot stall, so nothing is held. The histogram is
// cleared after each emission. The store persists until reset.
// Reset clears the store count, the touched bits and both csr registers.
// The csr channel is always ready; it is to be written only while busy is low, which the block does not enforce.
// ----------------------------------------------------------------------------
module angular_momentum_fusion_multiplicity #(
   parameter int MAX_FIRST_ENTRIES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_func,
   input  logic [amfm_pkg::SPIN_W-1:0]        req_entry_spin,
   input  logic [amfm_pkg::MULT_IN_W-1:0]     req_entry_mult,
   input  logic                               req_final_entry,
   output logic                               rsp_valid,
   output logic [amfm_pkg::BIN_W-1:0]         rsp_out_spin,
   output logic [amfm_pkg::SUM_W-1:0]         rsp_out_mult,
   output logic [amfm_pkg::BIN_W-1:0]         rsp_out_degeneracy,
   output logic                               rsp_saturated,
   output logic                               rsp_run_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [amfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [amfm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import amfm_pkg::*;

   localparam int CNT_W = $clog2(MAX_FIRST_ENTRIES + 1);
   localparam int IDX_W = (MAX_FIRST_ENTRIES > 1) ? $clog2(MAX_FIRST_ENTRIES) : 1;
   localparam int OCNT_W = $clog2(MAX_OUT + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SREAD    = 4'd1;
   localparam logic [3:0] S_MUL      = 4'd2;
   localparam logic [3:0] S_BIN      = 4'd3;
   localparam logic [3:0] S_FUSED    = 4'd4;
   localparam logic [3:0] S_SCAN     = 4'd5;
   localparam logic [3:0] S_SCAN_END = 4'd6;
   localparam logic [3:0] S_FLUSH    = 4'd7;
   localparam logic [3:0] S_TGT      = 4'd8;
   localparam logic [3:0] S_TGT_OUT  = 4'd9;

   entry_type            store_mem [MAX_FIRST_ENTRIES];
   entry_type            store_q_ff;
   entry_type            load_entry;
   logic                 load_go;

   logic [3:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [SPIN_W-1:0]    item_spin_ff, item_spin_in;
   logic [MULT_BITS-1:0] item_mult_ff, item_mult_in;
   logic                 item_final_ff, item_final_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [BIN_W-1:0]     hi_ff, hi_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [BIN_W-1:0]     wr_bin_ff, wr_bin_in;
   logic [BIN_W-1:0]     scan_ff, scan_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [BIN_W-1:0]     rd_bin_ff, rd_bin_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [BIN_W-1:0]     pend_spin_ff, pend_spin_in;
   logic [SUM_W-1:0]     pend_sum_ff, pend_sum_in;
   logic                 pend_sat_ff, pend_sat_in;
   logic [OCNT_W-1:0]    take_cnt_ff, take_cnt_in;
   logic                 target_only_ff, target_only_in;
   logic [BIN_W-1:0]     target_spin_ff, target_spin_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]     rsp_spin_ff, rsp_spin_in;
   logic [SUM_W-1:0]     rsp_mult_ff, rsp_mult_in;
   logic                 rsp_sat_ff, rsp_sat_in;
   logic                 rsp_end_ff, rsp_end_in;

   hist_ctl_type         hist_ctl;
   logic                 hist_seen;
   logic [SUM_W-1:0]     hist_sum;
   logic                 hist_sat;

   logic [SPIN_W-1:0]    spin_clamped;
   logic [SPIN_W-1:0]    lo_spin;
   logic [BIN_W-1:0]     hi_spin;

   amfm_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hist_ctl),
      .addend  (prod_ff),
      .rd_seen (hist_seen),
      .rd_sum  (hist_sum),
      .rd_sat  (hist_sat)
   );

   assign busy               = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_spin       = rsp_spin_ff;
   assign rsp_out_mult       = rsp_mult_ff;
   assign rsp_out_degeneracy = degeneracy(rsp_spin_ff);
   assign rsp_saturated      = rsp_sat_ff;
   assign rsp_run_end        = rsp_end_ff;

   assign spin_clamped = (req_entry_spin > SPIN_W'(MAX_IN_SPIN)) ?
                         SPIN_W'(MAX_IN_SPIN) : req_entry_spin;
   assign load_entry.spin = spin_clamped;
   assign load_entry.mult = req_entry_mult[MULT_BITS-1:0];
   assign load_go = start && !busy && !req_func &&
                    (count_ff < CNT_W'(MAX_FIRST_ENTRIES));

   assign lo_spin = (store_q_ff.spin > item_spin_ff) ? store_q_ff.spin - item_spin_ff :
                                                       item_spin_ff - store_q_ff.spin;
   assign hi_spin = BIN_W'(store_q_ff.spin) + BIN_W'(item_spin_ff);

   always_comb begin
      target_only_in = target_only_ff;
      target_spin_in = target_spin_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TARGET_ONLY: target_only_in = csr_wdata[0];
            CSR_TARGET_SPIN: target_spin_in = csr_wdata[BIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      item_spin_in  = item_spin_ff;
      item_mult_in  = item_mult_ff;
      item_final_in = item_final_ff;
      prod_in       = prod_ff;
      bin_in        = bin_ff;
      hi_in         = hi_ff;
      wr_pend_in    = 1'b0;
      wr_bin_in     = wr_bin_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_bin_in     = rd_bin_ff;
      pend_valid_in = pend_valid_ff;
      pend_spin_in  = pend_spin_ff;
      pend_sum_in   = pend_sum_ff;
      pend_sat_in   = pend_sat_ff;
      take_cnt_in   = take_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_spin_in   = rsp_spin_ff;
      rsp_mult_in   = rsp_mult_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_end_in    = rsp_end_ff;

      hist_ctl.rd_bin = bin_ff;
      hist_ctl.wr_en  = wr_pend_ff;
      hist_ctl.wr_bin = wr_bin_ff;
      hist_ctl.clear  = 1'b0;

      // hold one touched bin back so the last one can carry run_end
      if (rd_pend_ff && hist_seen && (take_cnt_ff != OCNT_W'(MAX_OUT))) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_spin_in  = pend_spin_ff;
            rsp_mult_in  = pend_sum_ff;
            rsp_sat_in   = pend_sat_ff;
            rsp_end_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_spin_in  = rd_bin_ff;
         pend_sum_in   = hist_sum;
         pend_sat_in   = hist_sat;
         take_cnt_in   = take_cnt_ff + OCNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (!req_func) begin
                  if (load_go) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  item_spin_in  = spin_clamped;
                  item_mult_in  = req_entry_mult[MULT_BITS-1:0];
                  item_final_in = req_final_entry;
                  idx_in        = '0;
                  state_in      = (count_ff == '0) ? S_FUSED : S_SREAD;
               end
            end
         end
         S_SREAD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(store_q_ff.mult) * PROD_W'(item_mult_ff);
            bin_in   = BIN_W'(lo_spin);
            hi_in    = hi_spin;
            state_in = S_BIN;
         end
         S_BIN: begin
            hist_ctl.rd_bin = bin_ff;
            wr_pend_in      = 1'b1;
            wr_bin_in       = bin_ff;
            bin_in          = bin_ff + BIN_W'(2);
            if (bin_ff == hi_ff) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ((idx_ff + CNT_W'(1)) == count_ff) ? S_FUSED : S_SREAD;
            end
         end
         S_FUSED: begin
            scan_in = '0;
            if (!item_final_ff) begin
               state_in = S_IDLE;
            end else if (target_only_ff) begin
               state_in = S_TGT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            hist_ctl.rd_bin = scan_ff;
            rd_pend_in      = 1'b1;
            rd_bin_in       = scan_ff;
            scan_in         = scan_ff + BIN_W'(1);
            if (scan_ff == BIN_W'(NBINS - 1)) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_spin_in  = pend_spin_ff;
               rsp_mult_in  = pend_sum_ff;
               rsp_sat_in   = pend_sat_ff;
               rsp_end_in   = 1'b1;
            end
            pend_valid_in  = 1'b0;
            take_cnt_in    = '0;
            hist_ctl.clear = 1'b1;
            state_in       = S_IDLE;
         end
         S_TGT: begin
            hist_ctl.rd_bin = target_spin_ff;
            state_in        = S_TGT_OUT;
         end
         S_TGT_OUT: begin
            rsp_valid_in   = 1'b1;
            rsp_spin_in    = target_spin_ff;
            rsp_mult_in    = hist_sum;
            rsp_sat_in     = hist_sat;
            rsp_end_in     = 1'b1;
            hist_ctl.clear = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_go) begin
         store_mem[count_ff[IDX_W-1:0]] <= load_entry;
      end
      store_q_ff <= store_mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         wr_pend_ff     <= 1'b0;
         rd_pend_ff     <= 1'b0;
         pend_valid_ff  <= 1'b0;
         take_cnt_ff    <= '0;
         target_only_ff <= 1'b0;
         target_spin_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         wr_pend_ff     <= wr_pend_in;
         rd_pend_ff     <= rd_pend_in;
         pend_valid_ff  <= pend_valid_in;
         take_cnt_ff    <= take_cnt_in;
         target_only_ff <= target_only_in;
         target_spin_ff <= target_spin_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      item_spin_ff  <= item_spin_in;
      item_mult_ff  <= item_mult_in;
      item_final_ff <= item_final_in;
      prod_ff       <= prod_in;
      bin_ff        <= bin_in;
      hi_ff         <= hi_in;
      wr_bin_ff     <= wr_bin_in;
      scan_ff       <= scan_in;
      rd_bin_ff     <= rd_bin_in;
      pend_spin_ff  <= pend_spin_in;
      pend_sum_ff   <= pend_sum_in;
      pend_sat_ff   <= pend_sat_in;
      rsp_spin_ff   <= rsp_spin_in;
      rsp_mult_ff   <= rsp_mult_in;
      rsp_sat_ff    <= rsp_sat_in;
      rsp_end_ff    <= rsp_end_in;
   end

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result issued without a transaction in progress");

   a_write_in_fuse: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == S_BIN || state_ff == S_SREAD || state_ff == S_FUSED))
      else $error("histogram write outside fuse sequence");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FIRST_ENTRIES))
      else $error("store count beyond capacity");

   a_run_end_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_end) |=> !rsp_valid)
      else $error("result follows end of run");

endmodule
